// ===== hw/rtl/lattice_coefficient_bit_packer_assert.svh =====
// Assertion macros for the bit packer.
`ifndef LATTICE_COEFFICIENT_BIT_PACKER_ASSERT_SVH
`define LATTICE_COEFFICIENT_BIT_PACKER_ASSERT_SVH

`ifndef SYNTH
`define LCBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LCBP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define LCBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/lcbp_pkg.sv =====
package lcbp_pkg;

    localparam int AccW    = 25;
    localparam int PendW   = 3;
    localparam int NbW     = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 18;
    localparam int QDepth  = 4;
    localparam int QPtrW   = $clog2(QDepth);

    localparam logic [2:0] FmtSix   = 3'd0;
    localparam logic [2:0] FmtGamma = 3'd1;
    localparam logic [2:0] FmtLow   = 3'd2;
    localparam logic [2:0] FmtTen   = 3'd3;
    localparam logic [2:0] FmtEta   = 3'd4;

    localparam logic [CfgIdxW-1:0] CfgFormat = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgGamma  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgEta    = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgLow    = 2'd3;

    localparam logic [2:0]  FormatRst = 3'd0;
    localparam logic [17:0] GammaRst  = 18'd131072;
    localparam logic [1:0]  EtaRst    = 2'd2;
    localparam logic [12:0] LowRst    = 13'd4096;

    typedef struct packed {
        logic [AccW-1:0] word;
        logic [NbW-1:0]  nbytes;
        logic            eop;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_stat;

endpackage

// ===== hw/rtl/lcbp_front.sv =====
module lcbp_front #(
    parameter int COEFF_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [lcbp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [lcbp_pkg::CfgDatW-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [COEFF_BITS-1:0]        i_coefficient,
    input  logic                         i_last_coefficient,
    input  lcbp_pkg::t_q_stat            i_q_stat,
    output lcbp_pkg::t_push              o_push
);

    logic [2:0]  r_format;
    logic [17:0] r_gamma;
    logic [1:0]  r_eta;
    logic [12:0] r_low;

    logic [lcbp_pkg::AccW-1:0]  r_acc, n_acc;
    logic [lcbp_pkg::PendW-1:0] r_pend, n_pend;

    logic [17:0]               field;
    logic [4:0]                width;
    logic [lcbp_pkg::AccW-1:0] merged;
    logic [4:0]                total;
    logic [1:0]                full_bytes;
    logic [2:0]                rem_bits;
    logic                      accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= lcbp_pkg::FormatRst;
            r_gamma  <= lcbp_pkg::GammaRst;
            r_eta    <= lcbp_pkg::EtaRst;
            r_low    <= lcbp_pkg::LowRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lcbp_pkg::CfgFormat: r_format <= i_cfg_data[2:0];
                lcbp_pkg::CfgGamma:  r_gamma  <= i_cfg_data[17:0];
                lcbp_pkg::CfgEta:    r_eta    <= i_cfg_data[1:0];
                lcbp_pkg::CfgLow:    r_low    <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_format)
            lcbp_pkg::FmtSix: begin
                field = {12'd0, i_coefficient[5:0]};
                width = 5'd6;
            end
            lcbp_pkg::FmtGamma: begin
                field = r_gamma - i_coefficient[17:0];
                width = 5'd18;
            end
            lcbp_pkg::FmtLow: begin
                field = {5'd0, r_low - i_coefficient[12:0]};
                width = 5'd13;
            end
            lcbp_pkg::FmtTen: begin
                field = {8'd0, i_coefficient[9:0]};
                width = 5'd10;
            end
            lcbp_pkg::FmtEta: begin
                field = {15'd0, {1'b0, r_eta} - i_coefficient[2:0]};
                width = 5'd3;
            end
            default: begin
                field = 18'd0;
                width = 5'd0;
            end
        endcase
    end

    assign o_ready    = !i_q_stat.full;
    assign accept     = i_valid && o_ready;
    assign merged     = r_acc | ({{(lcbp_pkg::AccW-18){1'b0}}, field} << r_pend);
    assign total      = {2'd0, r_pend} + width;
    assign full_bytes = total[4:3];
    assign rem_bits   = total[2:0];

    always_comb begin
        o_push.entry.word   = merged;
        o_push.entry.nbytes = {1'b0, full_bytes}
                            + {2'd0, i_last_coefficient && (rem_bits != 3'd0)};
        o_push.entry.eop    = i_last_coefficient;
        o_push.valid        = accept && (o_push.entry.nbytes != 3'd0);
        if (i_last_coefficient) begin
            n_acc  = '0;
            n_pend = '0;
        end else begin
            n_acc  = merged >> {full_bytes, 3'b000};
            n_pend = rem_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
        end else if (accept) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

endmodule

// ===== hw/rtl/lcbp_queue.sv =====
module lcbp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcbp_pkg::t_push     i_push,
    input  logic                i_pop,
    output lcbp_pkg::t_entry    o_head,
    output lcbp_pkg::t_q_stat   o_stat
);

    lcbp_pkg::t_entry r_mem [lcbp_pkg::QDepth];

    logic [lcbp_pkg::QPtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [lcbp_pkg::QPtrW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + {{lcbp_pkg::QPtrW{1'b0}}, i_push.valid}
                               - {{lcbp_pkg::QPtrW{1'b0}}, i_pop};
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (lcbp_pkg::QPtrW+1)'(lcbp_pkg::QDepth));

endmodule

// ===== hw/rtl/lcbp_back.sv =====
module lcbp_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcbp_pkg::t_entry      i_head,
    input  lcbp_pkg::t_q_stat     i_q_stat,
    output lcbp_pkg::t_back_stat  o_stat,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_packed_byte,
    output logic                  o_end_of_polynomial
);

    logic [lcbp_pkg::AccW-1:0] r_word;
    logic [lcbp_pkg::NbW-1:0]  r_left;
    logic                      r_eop;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte;
    logic                      r_out_eop;
    logic                      adv;
    logic                      pop;

    assign adv = !r_out_valid || i_ready;
    assign pop = !i_q_stat.empty && ((r_left == '0) || (adv && (r_left == 3'd1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_left <= i_head.nbytes;
            end else if (adv && (r_left != '0)) begin
                r_left <= r_left - 1'b1;
            end
            if (adv) begin
                r_out_valid <= (r_left != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_word <= i_head.word;
            r_eop  <= i_head.eop;
        end else if (adv && (r_left != '0)) begin
            r_word <= r_word >> 8;
        end
        if (adv && (r_left != '0)) begin
            r_out_byte <= r_word[7:0];
            r_out_eop  <= r_eop && (r_left == 3'd1);
        end
    end

    assign o_stat.pop          = pop;
    assign o_stat.busy         = (r_left != '0);
    assign o_valid             = r_out_valid;
    assign o_packed_byte       = r_out_byte;
    assign o_end_of_polynomial = r_out_eop;

endmodule

// ===== hw/rtl/lattice_coefficient_bit_packer.sv =====
// Accepted coefficients pass the queue, shift and output registers to o_valid.
// Throughput: one byte per cycle at the output register while i_ready is high; a
// coefficient completes up to 3 bytes, 4 with the closing byte.
// The single byte-wide output port sets the rate; a 4-entry queue decouples input.
// Reset: i_rst_n synchronous, active low; clears the accumulator, queue and
// output valid, and loads format 0 and the default offsets.
module lattice_coefficient_bit_packer #(
    parameter int COEFF_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lcbp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [lcbp_pkg::CfgDatW-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [COEFF_BITS-1:0]        i_coefficient,
    input  logic                         i_last_coefficient,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [7:0]                   o_packed_byte,
    output logic                         o_end_of_polynomial
);

    lcbp_pkg::t_push      push;
    lcbp_pkg::t_entry     head;
    lcbp_pkg::t_q_stat    q_stat;
    lcbp_pkg::t_back_stat bk_stat;

    assign o_cfg_ready = 1'b1;

    lcbp_front #(
        .COEFF_BITS(COEFF_BITS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_coefficient      (i_coefficient),
        .i_last_coefficient (i_last_coefficient),
        .i_q_stat           (q_stat),
        .o_push             (push)
    );

    lcbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (bk_stat.pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    lcbp_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head              (head),
        .i_q_stat            (q_stat),
        .o_stat              (bk_stat),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_packed_byte       (o_packed_byte),
        .o_end_of_polynomial (o_end_of_polynomial)
    );

`include "lattice_coefficient_bit_packer_assert.svh"

    `LCBP_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, push.valid, !q_stat.full, "queue overflow")
    `LCBP_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, bk_stat.pop, !q_stat.empty, "queue underflow")
    `LCBP_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, bk_stat.pop, bk_stat.busy, "empty transaction loaded")

endmodule
